FILE: rtl/core/ctbd_pkg.sv
// Package for the capacitive touch baseline detector.
// Holds widths, register indexes, reset values and the per-channel state types.
// Used by every module under rtl/core.
package ctbd_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = 3;
  localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_W  = 16;
  localparam int BASE_W    = 24;
  localparam int FRAC_W    = 8;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = COEF_W + BASE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_THR_IDX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_IDX = 1'd1;

  localparam logic [SAMPLE_W-1:0] THR_RESET  = 16'd20;
  localparam logic [COEF_W-1:0]   COEF_RESET = 16'd655;

  // Half of one Q0.16 unit, for round to nearest.
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_UP,
    DIR_DOWN
  } ctbd_dir_e;

  // One word of the per-channel state memory.
  typedef struct packed {
    logic                touch;
    logic [SAMPLE_W-1:0] prev;
    logic [BASE_W-1:0]   base;
  } ctbd_entry_t;

  // Result of the compare stage, handed to the tracking stages.
  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic                ok;
    logic                hit;
    logic [SAMPLE_W-1:0] filt;
    logic [SAMPLE_W-1:0] prev_new;
    logic [BASE_W-1:0]   base;
    logic [BASE_W-1:0]   mag;
    ctbd_dir_e           dir;
  } ctbd_eval_t;

endpackage

FILE: rtl/core/capacitive_touch_baseline_detector.sv
// Capacitive touch detector with a per-channel IIR baseline held in a state memory.
// Takes one item per clock while the output is not stalled and each item's channel
// differs from the channels of the two items before it; an item for a channel whose
// update is still in the two stages behind the memory read waits until that write
// lands. Results pass the compare, multiply and write stages, then the output
// register. The primed flags sit in flip-flops that reset clears, so no clearing pass
// is needed. Depends on ctbd_pkg, ctbd_state_ram, ctbd_eval and ctbd_track_mult.
module capacitive_touch_baseline_detector import ctbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CH_W-1:0]      channel_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 recalibrate_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CH_W-1:0]      out_channel_o,
  output logic                 touched_o,
  output logic [SAMPLE_W-1:0]  filtered_o,
  output logic [BASE_W-1:0]    baseline_out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  // Configuration
  logic [SAMPLE_W-1:0] thr_q;
  logic [COEF_W-1:0]   coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      coef_q <= COEF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THR_IDX:  thr_q  <= cfg_data_i;
        CFG_COEF_IDX: coef_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline state
  logic                v1_q, v2_q, v3_q, out_valid_q;
  logic [CH_W-1:0]     ch1_q;
  logic [SAMPLE_W-1:0] smp1_q;
  logic                recal1_q, primed1_q;
  ctbd_eval_t          e2_q;
  logic [CH_W-1:0]     ch3_q;
  logic                ok3_q, hit3_q;
  logic [SAMPLE_W-1:0] filt3_q, prev3_q;
  logic [BASE_W-1:0]   base3_q, step3_q, mag3_q;
  ctbd_dir_e           dir3_q;
  logic [CHANNELS-1:0] primed_q;

  logic out_free, free3, free2, free1;
  logic adv3, adv2, adv1, accept, hazard;

  assign out_free = !out_valid_q || !out_stall_i;
  assign adv3     = v3_q && out_free;
  assign free3    = !v3_q || out_free;
  assign adv2     = v2_q && free3;
  assign free2    = !v2_q || free3;
  // Hold an item whose channel still has an update in flight.
  assign hazard   = (v2_q && (e2_q.ch == ch1_q)) || (v3_q && (ch3_q == ch1_q));
  assign adv1     = v1_q && free2 && !hazard;
  assign free1    = !v1_q || adv1;
  assign accept   = in_valid_i && free1;
  assign in_stall_o = !free1;

  // State memory
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  ctbd_entry_t       wr_data;
  ctbd_entry_t       entry;
  logic [BASE_W-1:0] base_new;

  // Re-read while an item is held so that later writes are seen.
  assign rd_addr = free1 ? channel_i[ADDR_W-1:0] : ch1_q[ADDR_W-1:0];
  assign wr_en   = adv3 && ok3_q;

  always_comb begin
    case (dir3_q)
      DIR_UP:   base_new = base3_q + step3_q;
      DIR_DOWN: base_new = base3_q - step3_q;
      DIR_HOLD: base_new = base3_q;
      default:  base_new = base3_q;
    endcase
  end

  assign wr_data.touch = hit3_q;
  assign wr_data.prev  = prev3_q;
  assign wr_data.base  = base_new;

  ctbd_state_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en),
    .waddr_i (ch3_q[ADDR_W-1:0]),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (entry)
  );

  // Stage 1: read data arrives, compare
  ctbd_eval_t eval;

  ctbd_eval u_eval (
    .ch_i     (ch1_q),
    .sample_i (smp1_q),
    .recal_i  (recal1_q),
    .primed_i (primed1_q),
    .entry_i  (entry),
    .thr_i    (thr_q),
    .eval_o   (eval)
  );

  // Stage 2: multiply
  logic [BASE_W-1:0] step;

  ctbd_track_mult u_mult (
    .coef_i (coef_q),
    .mag_i  (e2_q.mag),
    .step_o (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      primed_q    <= '0;
    end else begin
      if (free1) v1_q <= accept;
      if (free2) v2_q <= adv1;
      if (free3) v3_q <= adv2;
      if (out_free) out_valid_q <= adv3;
      if (accept && (32'(channel_i) < CHANNELS)) begin
        primed_q[channel_i[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch1_q     <= channel_i;
      smp1_q    <= sample_i;
      recal1_q  <= recalibrate_i;
      primed1_q <= primed_q[channel_i[ADDR_W-1:0]];
    end
    if (adv1) begin
      e2_q <= eval;
    end
    if (adv2) begin
      ch3_q   <= e2_q.ch;
      ok3_q   <= e2_q.ok;
      hit3_q  <= e2_q.hit;
      filt3_q <= e2_q.filt;
      prev3_q <= e2_q.prev_new;
      base3_q <= e2_q.base;
      mag3_q  <= e2_q.mag;
      dir3_q  <= e2_q.dir;
      step3_q <= step;
    end
    if (adv3) begin
      out_channel_o  <= ch3_q;
      touched_o      <= hit3_q;
      filtered_o     <= filt3_q;
      baseline_out_o <= base_new;
    end
  end

  assign out_valid_o = out_valid_q;

  // A rounded step never overshoots the target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (dir3_q != DIR_HOLD)) |-> (step3_q <= mag3_q))
    else $error("tracking step exceeds distance to target");

  // A touched result lies strictly below its own baseline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && touched_o) |-> ({filtered_o, FRAC_W'(0)} < baseline_out_o))
    else $error("touched result not below baseline");

  // A read that meets a write to the same entry returns the written word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (ch3_q[ADDR_W-1:0] == rd_addr)) |=> (entry == $past(wr_data)))
    else $error("state memory bypass lost a write");

endmodule

FILE: rtl/core/ctbd_state_ram.sv
// Per-channel state memory: one write port, one registered read port.
// A read that meets a write to the same entry returns the written word.
// Depends on ctbd_pkg.
module ctbd_state_ram import ctbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  ctbd_entry_t       wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output ctbd_entry_t       rdata_o
);

  ctbd_entry_t mem_q [CHANNELS];
  ctbd_entry_t rd_q;
  ctbd_entry_t byp_q;
  logic        byp_v_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q  <= mem_q[raddr_i];
    byp_q <= wdata_i;
  end

  // Flag a read that races a write to the same entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_v_q <= 1'b0;
    end else begin
      byp_v_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_v_q ? byp_q : rd_q;

endmodule

FILE: rtl/core/ctbd_eval.sv
// Compare stage: peak filter, touch test and signed distance to the baseline.
// Combinational; fed by the state memory read and the threshold register.
// Depends on ctbd_pkg.
module ctbd_eval import ctbd_pkg::*; (
  input  logic [CH_W-1:0]     ch_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                recal_i,
  input  logic                primed_i,
  input  ctbd_entry_t         entry_i,
  input  logic [SAMPLE_W-1:0] thr_i,
  output ctbd_eval_t          eval_o
);

  logic                ok;
  logic [SAMPLE_W-1:0] filt;
  logic [BASE_W-1:0]   fq;
  logic [BASE_W-1:0]   thr24;
  logic                hit;
  logic                up;

  assign ok    = 32'(ch_i) < CHANNELS;
  assign filt  = (sample_i > entry_i.prev) ? sample_i : entry_i.prev;
  assign fq    = {filt, FRAC_W'(0)};
  assign thr24 = {thr_i, FRAC_W'(0)};
  // A baseline below the threshold never reads as touched.
  assign hit   = (entry_i.base >= thr24) && (fq < (entry_i.base - thr24));
  assign up    = fq > entry_i.base;

  always_comb begin
    eval_o          = '0;
    eval_o.ch       = ch_i;
    eval_o.ok       = ok;
    eval_o.dir      = DIR_HOLD;
    if (ok) begin
      eval_o.prev_new = sample_i;
      if (recal_i || !primed_i) begin
        // Load baseline and history from this sample.
        eval_o.filt = sample_i;
        eval_o.base = {sample_i, FRAC_W'(0)};
      end else begin
        eval_o.filt = filt;
        eval_o.base = entry_i.base;
        eval_o.hit  = hit;
        eval_o.mag  = up ? (fq - entry_i.base) : (entry_i.base - fq);
        if (!hit && (fq != entry_i.base)) begin
          eval_o.dir = up ? DIR_UP : DIR_DOWN;
        end
      end
    end
  end

endmodule

FILE: rtl/core/ctbd_track_mult.sv
// Tracking step: coefficient times distance, rounded to nearest in Q0.16.
// Combinational multiply, registered by the caller.
// Depends on ctbd_pkg.
module ctbd_track_mult import ctbd_pkg::*; (
  input  logic [COEF_W-1:0] coef_i,
  input  logic [BASE_W-1:0] mag_i,
  output logic [BASE_W-1:0] step_o
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;

  assign prod    = PROD_W'(coef_i) * PROD_W'(mag_i);
  assign rounded = prod + ROUND_HALF;
  assign step_o  = rounded[PROD_W-1:COEF_W];

endmodule

FILE: verif/ctbd_result_checker.sv
// Result checker for the capacitive touch baseline detector testbench.
// Follows registers and per-channel state from the traffic it observes, predicts each
// result and compares it with the block's output. Depends on ctbd_pkg.
module ctbd_result_checker import ctbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CH_W-1:0]      channel_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 recalibrate_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [CH_W-1:0]      out_channel_i,
  input  logic                 touched_i,
  input  logic [SAMPLE_W-1:0]  filtered_i,
  input  logic [BASE_W-1:0]    baseline_out_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic                touched;
    logic [SAMPLE_W-1:0] filtered;
    logic [BASE_W-1:0]   baseline;
  } touch_report_t;

  touch_report_t       touch_reports_q[$];
  logic [SAMPLE_W-1:0] threshold_q;
  logic [COEF_W-1:0]   coef_q;
  logic [SAMPLE_W-1:0] prev_sample_mem [CHANNELS];
  logic [BASE_W-1:0]   baseline_mem    [CHANNELS];
  logic                primed_mem      [CHANNELS];

  // Advance one channel by one sample and return the report it should produce.
  function automatic touch_report_t update_channel(input logic [CH_W-1:0]     ch,
                                                   input logic [SAMPLE_W-1:0] smp,
                                                   input logic                recal);
    touch_report_t       rep;
    logic [SAMPLE_W-1:0] filt;
    logic [BASE_W-1:0]   target;
    logic [BASE_W-1:0]   thr_q8;
    logic [BASE_W-1:0]   base;
    logic [BASE_W-1:0]   mag;
    logic [PROD_W:0]     step_mag;
    logic                hit;
    rep = '0;
    rep.ch = ch;
    if (int'(ch) >= CHANNELS) return rep;
    if (recal || !primed_mem[ch]) begin
      prev_sample_mem[ch] = smp;
      baseline_mem[ch]    = {smp, 8'h00};
      primed_mem[ch]      = 1'b1;
      rep.filtered = smp;
      rep.baseline = {smp, 8'h00};
      return rep;
    end
    filt = (smp > prev_sample_mem[ch]) ? smp : prev_sample_mem[ch];
    prev_sample_mem[ch] = smp;
    target = {filt, 8'h00};
    thr_q8 = {threshold_q, 8'h00};
    base   = baseline_mem[ch];
    // A baseline under the threshold never reads as touched.
    hit = (base >= thr_q8) && (target < base - thr_q8);
    if (!hit && target != base) begin
      mag = (target > base) ? target - base : base - target;
      // Round to nearest, halves away from zero, on the magnitude.
      step_mag = ((PROD_W + 1)'(coef_q) * (PROD_W + 1)'(mag) + (PROD_W + 1)'(32768)) >> 16;
      if (target > base) baseline_mem[ch] = base + step_mag[BASE_W-1:0];
      else               baseline_mem[ch] = base - step_mag[BASE_W-1:0];
    end
    rep.touched  = hit;
    rep.filtered = filt;
    rep.baseline = baseline_mem[ch];
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    touch_report_t want;
    if (!rst_ni) begin
      threshold_q = THR_RESET;
      coef_q      = COEF_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        prev_sample_mem[c] = '0;
        baseline_mem[c]    = '0;
        primed_mem[c]      = 1'b0;
      end
      touch_reports_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (touch_reports_q.size() == 0) begin
          $error("result for channel %0d with no item outstanding", out_channel_i);
          fail_count_o++;
        end else begin
          want = touch_reports_q.pop_front();
          if (out_channel_i !== want.ch) begin
            $error("out_channel: expected %0d, actual %0d", want.ch, out_channel_i);
            fail_count_o++;
          end
          if (touched_i !== want.touched) begin
            $error("touched: expected %0d, actual %0d", want.touched, touched_i);
            fail_count_o++;
          end
          if (filtered_i !== want.filtered) begin
            $error("filtered: expected %0d, actual %0d", want.filtered, filtered_i);
            fail_count_o++;
          end
          if (baseline_out_i !== want.baseline) begin
            $error("baseline_out: expected %0d, actual %0d", want.baseline, baseline_out_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        touch_reports_q.push_back(update_channel(channel_i, sample_i, recalibrate_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THR_IDX:  threshold_q = cfg_data_i[SAMPLE_W-1:0];
          CFG_COEF_IDX: coef_q      = cfg_data_i[COEF_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = touch_reports_q.size();
  end

endmodule

FILE: verif/capacitive_touch_baseline_detector_tb.sv
// Testbench top for the capacitive touch baseline detector.
// Drives samples and register writes with random idling on both sides; checking is
// done by ctbd_result_checker. Depends on ctbd_pkg and the detector RTL.
module capacitive_touch_baseline_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctbd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 290;
  localparam int FINAL_ITEMS = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CH_W-1:0]      channel;
  logic [SAMPLE_W-1:0]  sample_in;
  logic                 recalibrate;
  logic                 out_valid;
  logic                 out_stall;
  logic [CH_W-1:0]      out_channel;
  logic                 touched;
  logic [SAMPLE_W-1:0]  filtered;
  logic [BASE_W-1:0]    baseline_out;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int              fail_count;
  int              pending;
  logic            quiet = 1'b0;
  int              gap_pct;
  int              idle_cycles = 0;
  int              cur_thr;
  logic [CH_W-1:0] last_ch;
  int              rest_level [CHANNELS];
  int              touch_left [CHANNELS];
  int              dip        [CHANNELS];

  capacitive_touch_baseline_detector uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .channel_i      (channel),
    .sample_i       (sample_in),
    .recalibrate_i  (recalibrate),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_channel_o  (out_channel),
    .touched_o      (touched),
    .filtered_o     (filtered),
    .baseline_out_o (baseline_out),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  ctbd_result_checker result_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .channel_i      (channel),
    .sample_i       (sample_in),
    .recalibrate_i  (recalibrate),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_channel_i  (out_channel),
    .touched_i      (touched),
    .filtered_i     (filtered),
    .baseline_out_i (baseline_out),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Called right after a falling edge; returns right after the falling edge that
  // follows acceptance.
  task automatic send_item(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                           input logic recal);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    = 1'b1;
    channel     = ch;
    sample_in   = smp;
    recalibrate = recal;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DAT_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly sensor-like traces (rest level, noise, touch dips), some raw noise and rail values.
  task automatic run_random(input int count);
    logic [CH_W-1:0] ch;
    int              lvl;
    int              pick;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      ch = ($urandom_range(0, 99) < 30) ? last_ch : CH_W'($urandom_range(0, CHANNELS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 31) == 0) rest_level[ch] += int'($urandom_range(0, 200)) - 100;
        if (touch_left[ch] == 0 && $urandom_range(0, 15) == 0) begin
          touch_left[ch] = $urandom_range(2, 12);
          dip[ch]        = $urandom_range(cur_thr / 2, cur_thr * 2 + 64);
        end
        lvl = rest_level[ch] + int'($urandom_range(0, 16)) - 8;
        if (touch_left[ch] > 0) begin
          lvl -= dip[ch];
          touch_left[ch]--;
        end
        if (lvl < 0) lvl = 0;
        else if (lvl > 65535) lvl = 65535;
      end else if (pick < 95) begin
        lvl = $urandom_range(0, 65535);
      end else begin
        lvl = ($urandom_range(0, 1) == 0) ? 0 : 65535;
      end
      send_item(ch, SAMPLE_W'(lvl), $urandom_range(0, 49) == 0);
      last_ch = ch;
    end
  endtask

  // Random output backpressure in bursts; the rate changes now and then.
  initial begin
    int stall_pct;
    stall_pct = 10;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) begin
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
      end
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("capacitive_touch_baseline_detector test failed");
      $finish;
    end
  end

  initial begin
    int thr_set;
    int coef_set;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    channel     = '0;
    sample_in   = '0;
    recalibrate = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_THR_IDX;
    cfg_data    = '0;
    gap_pct     = 20;
    last_ch     = '0;
    cur_thr     = THR_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      rest_level[c] = 30000;
      touch_left[c] = 0;
      dip[c]        = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed items under the reset register values.
    send_item(0, 1000, 1'b0);   // first sample primes the channel
    send_item(0, 979, 1'b0);    // filtered equals baseline, no move
    send_item(0, 979, 1'b0);    // just below baseline minus threshold
    send_item(0, 980, 1'b0);    // exactly at the threshold, not touched
    send_item(1, 0, 1'b0);
    send_item(1, 0, 1'b0);      // baseline under threshold, never touched
    send_item(1, 65535, 1'b0);  // full-scale step up
    send_item(2, 65535, 1'b0);
    send_item(2, 0, 1'b0);      // previous sample still wins the max
    send_item(2, 0, 1'b0);      // deep touch
    send_item(2, 0, 1'b1);      // recalibrate a primed channel
    send_item(3, 12345, 1'b1);  // recalibrate before the first sample
    send_item(3, 65535, 1'b1);
    send_item(3, 0, 1'b1);
    send_item(4, 32768, 1'b0);
    send_item(5, 1, 1'b0);
    send_item(5, 0, 1'b0);      // previous sample wins the max, no move
    send_item(6, 65534, 1'b0);
    send_item(7, 16'hAAAA, 1'b0);
    send_item(7, 16'h5555, 1'b0);
    send_item(7, 16'hAAAA, 1'b0);

    for (int p = 0; p <= PHASES; p++) begin
      // Hold off register writes until the pipeline has drained.
      in_valid = 1'b0;
      while (pending != 0) @(negedge clk);
      repeat (6) @(negedge clk);
      case (p)
        0: begin thr_set = 0;     coef_set = 65535; end
        1: begin thr_set = 65535; coef_set = 0;     end
        2: begin thr_set = 50;    coef_set = 4096;  end
        3: begin thr_set = 0;     coef_set = 0;     end
        4: begin thr_set = 65535; coef_set = 65535; end
        5: begin
          thr_set  = $urandom_range(0, 400);
          coef_set = $urandom_range(0, 65535);
        end
        default: begin thr_set = THR_RESET; coef_set = COEF_RESET; end
      endcase
      write_register(CFG_THR_IDX, thr_set);
      write_register(CFG_COEF_IDX, coef_set);
      cur_thr = thr_set;
      for (int c = 0; c < CHANNELS; c++) begin
        rest_level[c] = $urandom_range(2000, 63000);
        touch_left[c] = 0;
      end
      if (p == PHASES) quiet = 1'b1;
      run_random((p == PHASES) ? FINAL_ITEMS : PHASE_ITEMS);
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("capacitive_touch_baseline_detector test passed");
    end else begin
      $display("capacitive_touch_baseline_detector test failed");
    end
    $finish;
  end

endmodule

FILE: capacitive_touch_baseline_detector.f
rtl/core/ctbd_pkg.sv
rtl/core/ctbd_state_ram.sv
rtl/core/ctbd_eval.sv
rtl/core/ctbd_track_mult.sv
rtl/core/capacitive_touch_baseline_detector.sv
verif/ctbd_result_checker.sv
verif/capacitive_touch_baseline_detector_tb.sv
